>>> hdl/rlbd_pkg.sv
// Shared constants, types and register codes for the resistor ladder key debouncer.
`default_nettype none

package rlbd_pkg;

  // Sample, band edge, run counter, key code, compare and register index widths, and the edge count.
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned EDGE_BITS   = 12;
  localparam int unsigned CNT_BITS    = 4;
  localparam int unsigned KEY_BITS    = 3;
  localparam int unsigned CMP_BITS    = (SAMPLE_BITS > EDGE_BITS) ? SAMPLE_BITS : EDGE_BITS;
  localparam int unsigned NUM_EDGES   = 5;
  localparam int unsigned IDX_BITS    = 3;

  typedef enum logic [KEY_BITS-1:0] {
    KEY_REC      = 3'd0,
    KEY_MODE     = 3'd1,
    KEY_PLAY     = 3'd2,
    KEY_SET      = 3'd3,
    KEY_VOL_DOWN = 3'd4,
    KEY_VOL_UP   = 3'd5,
    KEY_NONE     = 3'd6
  } key_e;

  // Register indexes on the configuration port.
  localparam logic [IDX_BITS-1:0] REG_EDGE_VOL_UP   = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_EDGE_VOL_DOWN = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_EDGE_SET      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_EDGE_PLAY     = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_EDGE_MODE     = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_IDLE_THRESH   = 3'd5;
  localparam logic [IDX_BITS-1:0] REG_STABLE        = 3'd6;

  // Reset values of the registers.
  localparam logic [EDGE_BITS-1:0] RST_EDGE_VOL_UP   = 12'd600;
  localparam logic [EDGE_BITS-1:0] RST_EDGE_VOL_DOWN = 12'd1000;
  localparam logic [EDGE_BITS-1:0] RST_EDGE_SET      = 12'd1380;
  localparam logic [EDGE_BITS-1:0] RST_EDGE_PLAY     = 12'd1780;
  localparam logic [EDGE_BITS-1:0] RST_EDGE_MODE     = 12'd2200;
  localparam logic [EDGE_BITS-1:0] RST_IDLE_THRESH   = 12'd2800;
  localparam logic [CNT_BITS-1:0]  RST_STABLE        = 4'd2;

  // Band edges in ascending order: vol up, vol down, set, play, mode.
  typedef struct packed {
    logic [NUM_EDGES-1:0][EDGE_BITS-1:0] edges;
    logic [EDGE_BITS-1:0]                idle_thresh;
  } band_cfg_t;

endpackage

`default_nettype wire

>>> hdl/rlbd_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
`default_nettype none

interface rlbd_in_if;
  logic                             valid;
  logic                             ready;
  logic [rlbd_pkg::SAMPLE_BITS-1:0] sample_mv;
  logic                             read_ok;

  modport source (output valid, output sample_mv, output read_ok, input ready);
  modport sink   (input valid, input sample_mv, input read_ok, output ready);
endinterface

interface rlbd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          press_event;
  logic [rlbd_pkg::KEY_BITS-1:0] key_code;
  logic [rlbd_pkg::KEY_BITS-1:0] observed_key;

  modport source (output valid, output press_event, output key_code, output observed_key,
                  input ready);
  modport sink   (input valid, input press_event, input key_code, input observed_key,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/rlbd_classify.sv
// Band classifier: maps one ladder sample to a key code.
`default_nettype none

module rlbd_classify (
  input  wire rlbd_pkg::band_cfg_t                 cfg_i,
  input  wire logic [rlbd_pkg::SAMPLE_BITS-1:0]    sample_mv_i,
  input  wire logic                                read_ok_i,
  output rlbd_pkg::key_e                           key_o
);
  import rlbd_pkg::*;

  localparam int unsigned NUM_BANDS = NUM_EDGES + 1;

  logic [CMP_BITS-1:0]                 mv;
  logic [NUM_BANDS-1:0][CMP_BITS-1:0]  lo;
  logic [NUM_BANDS-1:0][CMP_BITS-1:0]  hi;
  logic [NUM_BANDS-1:0]                hit;
  key_e                                band_key [NUM_BANDS];

  assign mv = CMP_BITS'(sample_mv_i);

  assign band_key[0] = KEY_VOL_UP;
  assign band_key[1] = KEY_VOL_DOWN;
  assign band_key[2] = KEY_SET;
  assign band_key[3] = KEY_PLAY;
  assign band_key[4] = KEY_MODE;
  assign band_key[5] = KEY_REC;

  // Band i runs from edge i-1 (zero for the first) up to edge i, the last
  // ending at the idle threshold. Out-of-order edges give an empty band.
  always_comb begin
    lo[0] = '0;
    for (int i = 1; i < NUM_BANDS; i++) begin
      lo[i] = CMP_BITS'(cfg_i.edges[i-1]);
    end
    for (int i = 0; i < NUM_EDGES; i++) begin
      hi[i] = CMP_BITS'(cfg_i.edges[i]);
    end
    hi[NUM_BANDS-1] = CMP_BITS'(cfg_i.idle_thresh);
    for (int i = 0; i < NUM_BANDS; i++) begin
      hit[i] = (mv >= lo[i]) && (mv < hi[i]);
    end
  end

  always_comb begin
    key_o = KEY_NONE;
    if (read_ok_i && (mv < CMP_BITS'(cfg_i.idle_thresh))) begin
      for (int i = NUM_BANDS - 1; i >= 0; i--) begin
        if (hit[i]) begin
          key_o = band_key[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/resistor_ladder_button_debouncer.sv
// Resistor ladder keypad: classifies each sample and debounces the key code.
// An accepted sample beat is registered in the input register, classified and
// debounced there, and its result beat is offered when that register moves on.
// Throughput: one sample beat per cycle; the input stalls only while the result
// register holds an untaken beat and the input register is full.
// Reset loads the default band edges and run length and returns to no key.
`default_nettype none

module resistor_ladder_button_debouncer (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [rlbd_pkg::IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [rlbd_pkg::EDGE_BITS-1:0]   cfg_data_i,
  rlbd_in_if.sink                               in_i,
  rlbd_out_if.source                            out_o
);
  import rlbd_pkg::*;

  // Configuration registers.
  band_cfg_t           cfg_q;
  logic [CNT_BITS-1:0] stable_q;

  // Input register.
  logic                   s1_vld_q;
  logic [SAMPLE_BITS-1:0] s1_mv_q;
  logic                   s1_ok_q;

  // Debounce state.
  key_e                cand_q, cand_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  key_e                conf_q, conf_d;
  logic                event_d;

  // Result register.
  logic out_vld_q;
  logic press_q;
  key_e obs_q;

  key_e obs;
  logic s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edges[0]    <= RST_EDGE_VOL_UP;
      cfg_q.edges[1]    <= RST_EDGE_VOL_DOWN;
      cfg_q.edges[2]    <= RST_EDGE_SET;
      cfg_q.edges[3]    <= RST_EDGE_PLAY;
      cfg_q.edges[4]    <= RST_EDGE_MODE;
      cfg_q.idle_thresh <= RST_IDLE_THRESH;
      stable_q          <= RST_STABLE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_EDGE_VOL_UP:   cfg_q.edges[0]    <= cfg_data_i;
        REG_EDGE_VOL_DOWN: cfg_q.edges[1]    <= cfg_data_i;
        REG_EDGE_SET:      cfg_q.edges[2]    <= cfg_data_i;
        REG_EDGE_PLAY:     cfg_q.edges[3]    <= cfg_data_i;
        REG_EDGE_MODE:     cfg_q.edges[4]    <= cfg_data_i;
        REG_IDLE_THRESH:   cfg_q.idle_thresh <= cfg_data_i;
        REG_STABLE:        stable_q          <= cfg_data_i[CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or is
  // being emptied in this cycle.
  assign s1_adv      = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_mv_q <= in_i.sample_mv;
      s1_ok_q <= in_i.read_ok;
    end
  end

  rlbd_classify u_classify (
    .cfg_i       (cfg_q),
    .sample_mv_i (s1_mv_q),
    .read_ok_i   (s1_ok_q),
    .key_o       (obs)
  );

  // Run counter saturates at the required length; a fresh key restarts at one.
  always_comb begin
    if (obs == cand_q) begin
      cand_d = cand_q;
      cnt_d  = (cnt_q < stable_q) ? cnt_q + 1'b1 : cnt_q;
    end else begin
      cand_d = obs;
      cnt_d  = CNT_BITS'(1);
    end
    conf_d  = conf_q;
    event_d = 1'b0;
    if ((cnt_d >= stable_q) && (cand_d != conf_q)) begin
      conf_d  = cand_d;
      event_d = (cand_d != KEY_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q    <= KEY_NONE;
      cnt_q     <= '0;
      conf_q    <= KEY_NONE;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        cand_q <= cand_d;
        cnt_q  <= cnt_d;
        conf_q <= conf_d;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      press_q <= event_d;
      obs_q   <= obs;
    end
  end

  // The confirmed key register doubles as the result's key code.
  assign out_o.valid        = out_vld_q;
  assign out_o.press_event  = press_q;
  assign out_o.key_code     = conf_q;
  assign out_o.observed_key = obs_q;

endmodule

`default_nettype wire
